### rtl/ctxh_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the context huffman text decoder
package ctxh_pkg;

    localparam int CFG_AW = 4;

    typedef enum logic [1:0] {
        REG_LEN_TABLE_COUNT  = 2'd0,
        REG_LOWEST_CONTEXT   = 2'd1,
        REG_SYMBOL_COUNT     = 2'd2,
        REG_HIGH_MARKER_CNT  = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_TABLE_WRITE = 1'b0,
        OP_STREAM_BYTE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_FIRST = 2'd1,
        PH_CODE  = 2'd2,
        PH_SPARE = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT_FIRST,
        S_NL_CHK,
        S_NL_W,
        S_BIT,
        S_BIT_CHK,
        S_CNT_W,
        S_LK_CHK,
        S_LK_W,
        S_OFF,
        S_OFF_W,
        S_CH,
        S_CH_W,
        S_EMIT_CH,
        S_EMIT_TERM,
        S_EMIT_ERR
    } state_t;

    typedef struct packed {
        logic [4:0] length_table_count;
        logic [7:0] lowest_context;
        logic [7:0] symbol_count;
        logic [4:0] high_marker_count;
    } cfg_t;

endpackage

### rtl/context_huffman_text_decoder.sv
`timescale 1ns / 1ps
// top level of the context huffman text decoder
//
// channel   dir  tdata                                   tuser        tlast
// s_        in   [11:0] table_address, [19:12] data_byte  [0] opcode   -
// m_        out  [7:0] out_char                          [0] error    last
// apb       in   registers at 0x0, 0x4, 0x8, 0xc         -            -
//
// table writes and count bytes are taken in the idle state without leaving it
// a code byte is consumed bit by bit, with length compares, length probes, boundary
// probes, context offset and character reads per decoded character and a terminator or
// error result, all reads on the one index memory read port
// results leave through one output register; the sequencer waits while it is full and m_tready is low
// reset is synchronous and clears all control state; the index memory is not cleared
module context_huffman_text_decoder #(
    parameter int INDEX_DEPTH  = 4096,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // table_address, data_byte, zero pad
    input  logic [0:0]                  s_tuser,   // opcode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // out_char
    output logic [0:0]                  m_tuser,   // error
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ctxh_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ctxh_pkg::*;

    localparam int AW = $clog2(INDEX_DEPTH);
    localparam int SW = 17;

    cfg_t   cfg;
    state_t state_reg, state_next;
    phase_t phase_reg;

    logic [7:0]  mem [INDEX_DEPTH];
    logic [7:0]  rdata_reg;
    logic [AW-1:0] rd_addr;

    logic [7:0]  sh_reg;
    logic [3:0]  bit_cnt_reg;
    logic [8:0]  chars_left_reg;
    logic [7:0]  prev_reg;
    logic [15:0] acc_reg;
    logic [4:0]  bits_held_reg;
    logic [4:0]  cur_len_reg;
    logic [15:0] cand_reg;
    logic [7:0]  code_rank_reg;
    logic [7:0]  rank_reg;
    logic [4:0]  scan_l_reg;
    logic        scan_adv_reg;
    logic        ret_bit_reg;
    logic [4:0]  li_reg;
    logic [4:0]  blk_reg;
    logic [7:0]  off_reg;
    logic [7:0]  ch_reg;

    logic        out_valid_reg;
    logic [7:0]  out_char_reg;
    logic        out_last_reg;
    logic        out_err_reg;

    logic        s_fire, emit_req, emit_go;
    opcode_t     op;
    logic [11:0] in_addr;
    logic [7:0]  in_byte;
    logic [4:0]  len_lim;
    logic [16:0] diff;
    logic        match;
    logic [7:0]  ctx_diff;
    logic        in_range;
    logic [SW-1:0] h_base, c_base, b_base;
    logic [SW-1:0] lk_addr, off_addr, ch_addr;

    ctxh_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign op      = opcode_t'(s_tuser[0]);
    assign in_addr = s_tdata[11:0];
    assign in_byte = s_tdata[19:12];
    assign s_fire  = s_tvalid & s_tready;
    assign emit_go = emit_req & (~out_valid_reg | m_tready);

    assign len_lim  = (cfg.length_table_count < 5'(MAX_CODE_LEN)) ?
                      cfg.length_table_count : 5'(MAX_CODE_LEN);
    assign diff     = {1'b0, acc_reg} - {1'b0, cand_reg};
    assign match    = ~diff[16] & (diff[15:0] < {8'd0, rdata_reg});
    assign ctx_diff = prev_reg - cfg.lowest_context;
    assign in_range = (prev_reg >= cfg.lowest_context) & (ctx_diff < cfg.symbol_count);

    assign h_base   = SW'(cfg.length_table_count) + SW'(3);
    assign c_base   = h_base + SW'(cfg.high_marker_count);
    assign b_base   = c_base + SW'(cfg.symbol_count);
    assign lk_addr  = h_base + SW'(li_reg);
    assign off_addr = c_base + SW'(ctx_diff);
    assign ch_addr  = b_base + SW'({blk_reg, 8'd0}) + SW'(off_reg) + SW'(rank_reg);

    // index memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (s_fire && op == OP_TABLE_WRITE) begin
            mem[AW'(in_addr)] <= in_byte;
        end
        rdata_reg <= mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire && op == OP_STREAM_BYTE) begin
                    if (phase_reg == PH_FIRST) begin
                        state_next = S_EMIT_FIRST;
                    end else if (phase_reg == PH_CODE) begin
                        state_next = S_BIT;
                    end
                end
            end
            S_EMIT_FIRST, S_EMIT_CH: begin
                if (emit_go) begin
                    state_next = (chars_left_reg == 9'd1) ? S_EMIT_TERM : S_NL_CHK;
                end
            end
            S_NL_CHK: begin
                if (scan_l_reg > len_lim) begin
                    if (scan_adv_reg) begin
                        state_next = S_EMIT_ERR;
                    end else begin
                        state_next = ret_bit_reg ? S_BIT : S_IDLE;
                    end
                end else begin
                    state_next = S_NL_W;
                end
            end
            S_NL_W: begin
                if (rdata_reg != 8'd0) begin
                    state_next = (scan_adv_reg || ret_bit_reg) ? S_BIT : S_IDLE;
                end else begin
                    state_next = S_NL_CHK;
                end
            end
            S_BIT: begin
                state_next = (bit_cnt_reg == 4'd8) ? S_IDLE : S_BIT_CHK;
            end
            S_BIT_CHK: begin
                if (cur_len_reg == 5'd0) begin
                    state_next = S_EMIT_ERR;
                end else if (bits_held_reg < cur_len_reg) begin
                    state_next = S_BIT;
                end else begin
                    state_next = S_CNT_W;
                end
            end
            S_CNT_W: begin
                state_next = match ? S_LK_CHK : S_NL_CHK;
            end
            S_LK_CHK: begin
                state_next = (li_reg == cfg.high_marker_count) ? S_OFF : S_LK_W;
            end
            S_LK_W: begin
                state_next = (prev_reg <= rdata_reg) ? S_OFF : S_LK_CHK;
            end
            S_OFF: begin
                state_next = in_range ? S_OFF_W : S_CH;
            end
            S_OFF_W: state_next = S_CH;
            S_CH:    state_next = S_CH_W;
            S_CH_W:  state_next = S_EMIT_CH;
            S_EMIT_TERM, S_EMIT_ERR: begin
                if (emit_go) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready = 1'b0;
        emit_req = 1'b0;
        rd_addr  = '0;
        unique case (state_reg)
            S_IDLE:      s_tready = 1'b1;
            S_EMIT_FIRST, S_EMIT_CH, S_EMIT_TERM, S_EMIT_ERR: emit_req = 1'b1;
            S_NL_CHK:    rd_addr = AW'(scan_l_reg);
            S_BIT_CHK:   rd_addr = AW'(cur_len_reg);
            S_LK_CHK:    rd_addr = lk_addr[AW-1:0];
            S_OFF:       rd_addr = off_addr[AW-1:0];
            S_CH:        rd_addr = ch_addr[AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // decoder datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LEN;
            chars_left_reg <= 9'd0;
            prev_reg       <= 8'd0;
            acc_reg        <= 16'd0;
            bits_held_reg  <= 5'd0;
            cur_len_reg    <= 5'd0;
            cand_reg       <= 16'd0;
            code_rank_reg  <= 8'd0;
            bit_cnt_reg    <= 4'd0;
            scan_l_reg     <= 5'd0;
            scan_adv_reg   <= 1'b0;
            ret_bit_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire && op == OP_STREAM_BYTE) begin
                        sh_reg      <= in_byte;
                        bit_cnt_reg <= 4'd0;
                        if (phase_reg != PH_FIRST && phase_reg != PH_CODE) begin
                            chars_left_reg <= (in_byte != 8'd0) ? {1'b0, in_byte} : 9'd256;
                            phase_reg      <= PH_FIRST;
                        end
                    end
                end
                S_EMIT_FIRST, S_EMIT_CH: begin
                    if (emit_go) begin
                        prev_reg       <= (state_reg == S_EMIT_FIRST) ? sh_reg : ch_reg;
                        chars_left_reg <= chars_left_reg - 9'd1;
                        phase_reg      <= PH_CODE;
                        acc_reg        <= 16'd0;
                        bits_held_reg  <= 5'd0;
                        cand_reg       <= 16'd0;
                        code_rank_reg  <= 8'd0;
                        scan_l_reg     <= 5'd1;
                        scan_adv_reg   <= 1'b0;
                        ret_bit_reg    <= (state_reg == S_EMIT_CH);
                    end
                end
                S_NL_CHK: begin
                    if (scan_l_reg > len_lim && !scan_adv_reg) begin
                        cur_len_reg <= 5'd0;
                    end
                end
                S_NL_W: begin
                    if (rdata_reg != 8'd0) begin
                        cur_len_reg <= scan_l_reg;
                    end else begin
                        scan_l_reg <= scan_l_reg + 5'd1;
                        cand_reg   <= {cand_reg[14:0], 1'b0};
                    end
                end
                S_BIT: begin
                    if (bit_cnt_reg != 4'd8) begin
                        acc_reg       <= {acc_reg[14:0], sh_reg[0]};
                        sh_reg        <= {1'b0, sh_reg[7:1]};
                        bit_cnt_reg   <= bit_cnt_reg + 4'd1;
                        bits_held_reg <= bits_held_reg + 5'd1;
                    end
                end
                S_CNT_W: begin
                    if (match) begin
                        rank_reg <= code_rank_reg + diff[7:0];
                        li_reg   <= 5'd0;
                    end else begin
                        cand_reg      <= {cand_reg[14:0] + {7'd0, rdata_reg}, 1'b0};
                        code_rank_reg <= code_rank_reg + rdata_reg;
                        scan_l_reg    <= cur_len_reg + 5'd1;
                        scan_adv_reg  <= 1'b1;
                    end
                end
                S_LK_CHK: begin
                    if (li_reg == cfg.high_marker_count) begin
                        blk_reg <= (li_reg == 5'd0) ? 5'd0 : li_reg - 5'd1;
                    end
                end
                S_LK_W: begin
                    if (prev_reg <= rdata_reg) begin
                        blk_reg <= li_reg;
                    end else begin
                        li_reg <= li_reg + 5'd1;
                    end
                end
                S_OFF: begin
                    off_reg <= 8'd0;
                end
                S_OFF_W: off_reg <= rdata_reg;
                S_CH_W:  ch_reg  <= rdata_reg;
                S_EMIT_TERM, S_EMIT_ERR: begin
                    if (emit_go) begin
                        phase_reg <= PH_LEN;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit_go) begin
            out_valid_reg <= 1'b1;
            out_last_reg  <= (state_reg == S_EMIT_TERM) || (state_reg == S_EMIT_ERR);
            out_err_reg   <= (state_reg == S_EMIT_ERR);
            unique case (state_reg)
                S_EMIT_FIRST: out_char_reg <= sh_reg;
                S_EMIT_CH:    out_char_reg <= ch_reg;
                default:      out_char_reg <= 8'd0;
            endcase
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_char_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_err_reg;

endmodule

### rtl/ctxh_regs.sv
`timescale 1ns / 1ps
// apb configuration registers of the context huffman text decoder
module ctxh_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ctxh_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output ctxh_pkg::cfg_t             cfg
);
    import ctxh_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.length_table_count <= 5'd1;
            cfg_reg.lowest_context     <= 8'd0;
            cfg_reg.symbol_count       <= 8'd0;
            cfg_reg.high_marker_count  <= 5'd1;
        end else if (wr_en) begin
            unique case (idx)
                REG_LEN_TABLE_COUNT: cfg_reg.length_table_count <= pwdata[4:0];
                REG_LOWEST_CONTEXT:  cfg_reg.lowest_context     <= pwdata[7:0];
                REG_SYMBOL_COUNT:    cfg_reg.symbol_count       <= pwdata[7:0];
                REG_HIGH_MARKER_CNT: cfg_reg.high_marker_count  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LEN_TABLE_COUNT: prdata = {27'd0, cfg_reg.length_table_count};
            REG_LOWEST_CONTEXT:  prdata = {24'd0, cfg_reg.lowest_context};
            REG_SYMBOL_COUNT:    prdata = {24'd0, cfg_reg.symbol_count};
            REG_HIGH_MARKER_CNT: prdata = {27'd0, cfg_reg.high_marker_count};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

### rtl/ctxh_checker.sv
`timescale 1ns / 1ps
// port checker of the context huffman text decoder and its binding
module ctxh_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [23:0]                 s_tdata,
    input logic [0:0]                  s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [7:0]                  m_tdata,
    input logic [0:0]                  m_tuser,
    input logic                        m_tlast,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [ctxh_pkg::CFG_AW-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        pready
);

    // a stalled transfer holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // an error result closes the message
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("error result without last");

    // terminator carries a nul
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == 8'd0)
        else $error("terminator not nul");

    // reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind context_huffman_text_decoder ctxh_checker u_ctxh_checker (.*);

### dv/tb_context_huffman_text_decoder.sv
`timescale 1ns / 1ps
// testbench of the context huffman text decoder: random tables and code streams against a predictor
module tb_context_huffman_text_decoder;
    import ctxh_pkg::*;

    localparam int MEM_DEPTH = 4096;
    localparam int LEN_CAP   = 16;

    class huff_scoreboard;
        typedef struct {
            bit [7:0] ch;
            bit       last;
            bit       err;
        } char_res_t;

        bit [7:0]  mem [MEM_DEPTH];
        bit [4:0]  ltc, hmc;
        bit [7:0]  low_ctx, sym_cnt;
        phase_t    phase;
        bit [8:0]  left;
        bit [7:0]  prev;
        bit [15:0] acc;
        bit [4:0]  held, cur;
        bit [15:0] cand;
        bit [7:0]  rank_base;
        char_res_t pending [$];
        int        errors, checked, n_err_res, n_msgs;

        function new();
            ltc = 1;
            hmc = 1;
            low_ctx = 0;
            sym_cnt = 0;
            phase = PH_LEN;
            left = 0;
            prev = 0;
            start_code();
        endfunction

        function int len_limit();
            return (ltc < LEN_CAP) ? ltc : LEN_CAP;
        endfunction

        function bit [4:0] next_len(int from);
            for (int l = from + 1; l <= len_limit(); l++)
                if (mem[l] != 0) return l[4:0];
            return 0;
        endfunction

        function void start_code();
            acc = 0;
            held = 0;
            cand = 0;
            rank_base = 0;
            cur = next_len(0);
        endfunction

        function bit [7:0] pick_char(bit [7:0] p, bit [7:0] rank);
            int h, c, b, blk, off;
            bit hit;
            h = ltc + 3;
            c = h + hmc;
            b = c + sym_cnt;
            blk = 0;
            off = 0;
            hit = 0;
            for (int i = 0; i < hmc; i++)
                if (!hit && p <= mem[(h + i) % MEM_DEPTH]) begin
                    blk = i;
                    hit = 1;
                end
            if (!hit && hmc != 0) blk = hmc - 1;
            if (p >= low_ctx && int'(p) - int'(low_ctx) < sym_cnt)
                off = mem[(c + p - low_ctx) % MEM_DEPTH];
            return mem[(b + (blk << 8) + off + rank) % MEM_DEPTH];
        endfunction

        function void add(bit [7:0] ch, bit last, bit err);
            char_res_t r;
            r.ch = ch;
            r.last = last;
            r.err = err;
            pending.push_back(r);
            if (err) n_err_res++;
            if (last) n_msgs++;
        endfunction

        function void set_reg(reg_idx_t idx, bit [31:0] v);
            case (idx)
                REG_LEN_TABLE_COUNT: ltc = v[4:0];
                REG_LOWEST_CONTEXT:  low_ctx = v[7:0];
                REG_SYMBOL_COUNT:    sym_cnt = v[7:0];
                REG_HIGH_MARKER_CNT: hmc = v[4:0];
            endcase
        endfunction

        function void note_input(opcode_t op, bit [11:0] a, bit [7:0] d);
            int cnt, nl;
            bit [7:0] ch;
            if (op == OP_TABLE_WRITE) begin
                mem[a] = d;
                return;
            end
            if (phase == PH_FIRST) begin
                add(d, 0, 0);
                prev = d;
                left = left - 9'd1;
                if (left == 0) begin
                    add(0, 1, 0);
                    phase = PH_LEN;
                end else begin
                    phase = PH_CODE;
                    start_code();
                end
                return;
            end
            if (phase != PH_CODE) begin
                left = (d != 0) ? 9'(d) : 9'd256;
                phase = PH_FIRST;
                return;
            end
            for (int b = 0; b < 8; b++) begin
                acc = {acc[14:0], d[b]};
                held++;
                if (cur == 0) begin
                    add(0, 1, 1);
                    phase = PH_LEN;
                    return;
                end
                if (held < cur) continue;
                cnt = mem[cur];
                if (acc >= cand && int'(acc) - int'(cand) < cnt) begin
                    ch = pick_char(prev, rank_base + 8'(acc - cand));
                    add(ch, 0, 0);
                    prev = ch;
                    left = left - 9'd1;
                    if (left == 0) begin
                        add(0, 1, 0);
                        phase = PH_LEN;
                        return;
                    end
                    start_code();
                end else begin
                    nl = next_len(cur);
                    if (nl == 0) begin
                        add(0, 1, 1);
                        phase = PH_LEN;
                        return;
                    end
                    cand = 16'((longint'(cand) + cnt) << (nl - cur));
                    rank_base = rank_base + 8'(cnt);
                    cur = nl[4:0];
                end
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check(bit [7:0] ch, bit last, bit err);
            char_res_t e;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected transfer char %0h last %0b err %0b", ch, last, err));
                return;
            end
            e = pending.pop_front();
            if (ch != e.ch) report($sformatf("char %0h, want %0h", ch, e.ch));
            if (last != e.last) report($sformatf("last %0b, want %0b", last, e.last));
            if (err != e.err) report($sformatf("error %0b, want %0b", err, e.err));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = 0;
    logic [0:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [CFG_AW-1:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    huff_scoreboard sb = new();
    int burst_left = 0;
    int stream_items = 0;
    int stall_mode = 0;
    int stall_cnt = 0;

    context_huffman_text_decoder dut (.*);

    always #5 aclk = ~aclk;

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check(m_tdata, m_tlast, m_tuser[0]);
        stall_cnt++;
        if (stall_cnt % 80 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic push_item(opcode_t op, bit [11:0] a, bit [7:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'b0, d, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, a, d);
        if (op == OP_STREAM_BYTE) stream_items++;
        burst_left--;
    endtask

    task automatic apb_write(reg_idx_t idx, bit [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'(idx) << 2;
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // idle the input, let all results drain, then reprogram and load a fresh header
    task automatic new_setting(int ltc, int low, int sc, int hmc);
        int lim, h, c;
        longint cap, cnt;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
        apb_write(REG_LEN_TABLE_COUNT, ltc);
        apb_write(REG_LOWEST_CONTEXT, low);
        apb_write(REG_SYMBOL_COUNT, sc);
        apb_write(REG_HIGH_MARKER_CNT, hmc);
        lim = (ltc < LEN_CAP) ? ltc : LEN_CAP;
        cap = 1;
        push_item(OP_TABLE_WRITE, 12'd0, 8'($urandom));
        for (int l = 1; l <= ltc; l++) begin
            if (l <= lim) begin
                cap = cap * 2;
                if (l == lim && $urandom_range(0, 5) != 0)
                    cnt = (cap < 255) ? cap : 255;
                else
                    cnt = $urandom_range(0, (cap < 4) ? cap : 4);
                cap = cap - cnt;
            end else begin
                cnt = $urandom_range(0, 255);
            end
            push_item(OP_TABLE_WRITE, 12'(l), 8'(cnt));
        end
        push_item(OP_TABLE_WRITE, 12'(ltc + 1), 8'($urandom));
        push_item(OP_TABLE_WRITE, 12'(ltc + 2), 8'($urandom));
        h = ltc + 3;
        for (int i = 0; i < hmc; i++)
            push_item(OP_TABLE_WRITE, 12'(h + i),
                      (i == hmc - 1 && $urandom_range(0, 3) != 0) ? 8'd255 :
                      8'(((i + 1) * 256) / (hmc + 1) + $urandom_range(0, 7)));
        c = h + hmc;
        for (int i = 0; i < sc; i++)
            push_item(OP_TABLE_WRITE, 12'(c + i), 8'($urandom));
    endtask

    task automatic send_message(int n, int first);
        push_item(OP_STREAM_BYTE, 12'($urandom), 8'(n));
        push_item(OP_STREAM_BYTE, 12'($urandom), (first < 0) ? 8'($urandom) : 8'(first));
        while (sb.phase == PH_CODE) begin
            if ($urandom_range(0, 19) == 0)
                push_item(OP_TABLE_WRITE, 12'($urandom_range(300, MEM_DEPTH - 1)),
                          8'($urandom));
            push_item(OP_STREAM_BYTE, 12'($urandom), 8'($urandom));
        end
    endtask

    function automatic int msg_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 0;
        if (r < 75) return $urandom_range(1, 12);
        return $urandom_range(13, 40);
    endfunction

    initial begin
        int target;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int a = 0; a < MEM_DEPTH; a++)
            push_item(OP_TABLE_WRITE, 12'(a), (a % 3 == 0) ? 8'(a) : 8'($urandom));
        push_item(OP_TABLE_WRITE, 12'd0, 8'h00);
        push_item(OP_TABLE_WRITE, 12'hfff, 8'hff);

        // directed cases
        new_setting(3, 10, 5, 2);
        send_message(1, 0);
        send_message(1, 255);
        send_message(2, 12);
        send_message(4, 9);
        send_message(3, 200);
        new_setting(0, 0, 0, 1);
        send_message(5, 65);
        new_setting(16, 255, 255, 16);
        send_message(6, 255);
        new_setting(1, 0, 0, 0);
        send_message(4, 3);
        push_item(OP_STREAM_BYTE, 12'd0, 8'h00);

        // fixed and random settings
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: new_setting(2, 0, 0, 1);
                1: new_setting(8, 97, 26, 4);
                2: new_setting(31, 255, 255, 31);
                default: new_setting($urandom_range(0, 16), $urandom_range(0, 255),
                                     $urandom_range(0, 255), $urandom_range(0, 16));
            endcase
            target = stream_items + 28;
            while (stream_items < target) begin
                if ($urandom_range(0, 9) == 0)
                    push_item(OP_STREAM_BYTE, 12'($urandom), 8'($urandom));
                else
                    send_message(msg_len(), -1);
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
        $display("stream bytes %0d, results checked %0d, messages %0d, error results %0d",
                 stream_items, sb.checked, sb.n_msgs, sb.n_err_res);
        $display("table settings visited: 11, mismatches %0d", sb.errors);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
